// ===== design/atan2_rational_approx_macros.svh =====
// Assertion macros for the arctangent block.
// Included by atan2_rational_approx, the module that carries concurrent assertions.
`ifndef ATAN2_RATIONAL_APPROX_MACROS_SVH
`define ATAN2_RATIONAL_APPROX_MACROS_SVH
`ifndef ASSERT_OFF
`define AR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define AR_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> nxt) else $error("%m failed");
`else
`define AR_ASSERT(label, clk, rst_n, prop)
`define AR_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ===== design/atan2_pkg.sv =====
// Constants and the octant code for the arctangent pipeline.
// Used by the top level and the testbench; depends on nothing.
package atan2_pkg;
    localparam int RATIO_FRAC = 15;
    localparam int COEF_FRAC  = 28;
    localparam longint unsigned COEF_A =
        (64'd16867629106 * (64'd1 << COEF_FRAC) + 64'd5000000000) / 64'd10000000000;
    localparam longint unsigned COEF_B =
        (64'd4378497304 * (64'd1 << COEF_FRAC) + 64'd5000000000) / 64'd10000000000;
    localparam longint unsigned COEF_C =
        (64'd16867633134 * (64'd1 << COEF_FRAC) + 64'd5000000000) / 64'd10000000000;
    localparam longint unsigned PI_Q32 = 64'h3243F6A89;

    typedef enum logic [1:0] {
        OCT_DIRECT = 2'd0,
        OCT_PLUS_PI = 2'd1,
        OCT_MINUS_PI = 2'd2,
        OCT_SWAPPED = 2'd3
    } octant_t;
endpackage

// ===== design/atan2_stream_if.sv =====
// Valid/ready stream interface with a generic payload.
// Depends on nothing.
interface atan2_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/atan2_rational_approx.sv =====
// Streaming four-quadrant arctangent in fixed point.
// Input items carry x_value and y_value (signed, IN_WIDTH bits). Output
// items carry angle (signed Q3.(ANGLE_WIDTH-3) radians) and origin_flag.
// One item is accepted per clock while the output is not stalled; results leave in input order.
// An accepted item passes through seventeen restoring division cells that
// form the Q1.15 ratio one bit per cell, three cells that square and scale
// it, ANGLE_WIDTH - 1 division cells that form the rational quotient and
// one register that applies the quadrant.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, the whole row holds; ready falls only while
// the output holds an untaken result, so nothing is lost.
// Reset clears all valid bits; no clearing pass is needed.
// The point (0,0) gives angle 0 with origin_flag set.
module atan2_rational_approx #(
    parameter int IN_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    atan2_stream_if.sink   in_s,
    atan2_stream_if.source out_s
);
    import atan2_pkg::*;
    `include "atan2_rational_approx_macros.svh"

    localparam int AF = ANGLE_WIDTH - 3;
    localparam int RW = IN_WIDTH + 1;
    localparam int QD = RATIO_FRAC + 2;
    localparam int NW = 64;
    localparam int TW = 32;
    localparam int DW2 = 40;
    localparam int QW2 = AF + 2;
    localparam int LS = QD + QW2 + 3;
    localparam int NS = LS + 1;
    localparam int SW = ANGLE_WIDTH + 3;
    localparam int NUP = (AF >= RATIO_FRAC) ? AF - RATIO_FRAC : 0;
    localparam int DUP = (AF >= RATIO_FRAC) ? 0 : RATIO_FRAC - AF;
    localparam longint signed PI_ANG =
        longint'((PI_Q32 + (64'd1 << (31 - AF))) >> (32 - AF));
    localparam longint signed HALF_PI_ANG =
        longint'((PI_Q32 + (64'd1 << (32 - AF))) >> (33 - AF));
    localparam logic signed [SW-1:0] PI_S = SW'(PI_ANG);
    localparam logic signed [SW-1:0] HPI_S = SW'(HALF_PI_ANG);
    localparam logic [QD-1:0] V_MAX = QD'((1 << RATIO_FRAC) - 1);

    logic en;
    logic [NS-1:0] vld_reg;
    assign en = !vld_reg[NS-1] || out_s.ready;
    assign in_s.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-2:0], in_s.valid};
    end

    // Side data travelling with each item.
    typedef struct packed {
        octant_t oct;
        logic    neg;
        logic    ysgn;
        logic    org;
    } side_t;
    side_t side_reg [1:LS];

    logic [IN_WIDTH-1:0] xi, yi;
    logic [RW-1:0] ax, ay, num0, den0;
    side_t s0;
    always_comb
    begin
        xi = in_s.data[IN_WIDTH-1:0];
        yi = in_s.data[2*IN_WIDTH-1:IN_WIDTH];
        ax = xi[IN_WIDTH-1] ? {RW{1'b0}} - {1'b1, xi} : {1'b0, xi};
        ay = yi[IN_WIDTH-1] ? {RW{1'b0}} - {1'b1, yi} : {1'b0, yi};
        s0.org = (xi == '0) && (yi == '0);
        s0.neg = xi[IN_WIDTH-1] ^ yi[IN_WIDTH-1];
        s0.ysgn = yi[IN_WIDTH-1];
        if (ay < ax)
        begin
            if (!xi[IN_WIDTH-1])
                s0.oct = OCT_DIRECT;
            else if (yi[IN_WIDTH-1])
                s0.oct = OCT_MINUS_PI;
            else
                s0.oct = OCT_PLUS_PI;
            num0 = ay;
            den0 = {ax[RW-2:0], 1'b0};
        end
        else
        begin
            s0.oct = OCT_SWAPPED;
            num0 = ax;
            den0 = s0.org ? RW'(2) : {ay[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= s0;
            for (int k = 2; k <= LS; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // Ratio: num*2^17 / (2*den) gives floor(num*2^16/den) in QD bits.
    logic [RW:0]   drem [0:QD];
    logic [RW-1:0] dden [0:QD];
    logic [QD-1:0] dq   [0:QD];
    assign drem[0] = {1'b0, num0};
    assign dden[0] = den0;
    assign dq[0] = '0;

    genvar g;
    generate
        for (g = 0; g < QD; g++)
        begin : g_div1
            atan2_div_cell #(.DW(RW), .QW(QD)) u_cell (
                .clk(clk), .en(en), .rem_in(drem[g]), .den_in(dden[g]),
                .q_in(dq[g]), .rem_out(drem[g+1]), .den_out(dden[g+1]),
                .q_out(dq[g+1])
            );
        end
    endgenerate

    // Halving with a carry in rounds the ratio to Q1.15.
    logic [QD:0]   qr;
    logic [QD-1:0] uv;
    assign qr = {1'b0, dq[QD]} + (QD+1)'(1);
    assign uv = (!side_reg[QD].neg && qr[QD:1] > V_MAX) ? V_MAX : qr[QD:1];

    // Polynomial cells: square, scale, multiply.
    logic [QD-1:0]    uv1_reg, uv2_reg;
    logic [2*QD-1:0]  v2_reg;
    logic [TW-1:0]    t_reg, dn_reg, dd_reg;
    logic [QD+TW-1:0] n_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uv1_reg <= uv;
            v2_reg <= uv * uv;
            uv2_reg <= uv1_reg;
            t_reg <= TW'(COEF_A + ((COEF_B * NW'(v2_reg)
                     + (NW'(1) << (2 * RATIO_FRAC - 1))) >> (2 * RATIO_FRAC)));
            dn_reg <= TW'(COEF_C + ((NW'(v2_reg) + NW'(2)) >> (2 * RATIO_FRAC - COEF_FRAC)));
            n_reg <= (QD+TW)'(uv2_reg) * (QD+TW)'(t_reg);
            dd_reg <= dn_reg;
        end
    end

    // Rational quotient floor(2n/d) after scaling to AF fraction bits.
    logic [NW-1:0]  n2, d2;
    logic [DW2:0]   arem [0:QW2];
    logic [DW2-1:0] aden [0:QW2];
    logic [QW2-1:0] aq   [0:QW2];
    assign n2 = NW'(n_reg) << (NUP + 1);
    assign d2 = NW'(dd_reg) << DUP;
    assign arem[0] = (DW2+1)'(n2 >> QW2);
    assign aden[0] = DW2'(d2);
    assign aq[0] = n2[QW2-1:0];

    generate
        for (g = 0; g < QW2; g++)
        begin : g_div2
            atan2_div_cell #(.DW(DW2), .QW(QW2)) u_cell (
                .clk(clk), .en(en), .rem_in(arem[g]), .den_in(aden[g]),
                .q_in(aq[g]), .rem_out(arem[g+1]), .den_out(aden[g+1]),
                .q_out(aq[g+1])
            );
        end
    endgenerate

    logic [QW2:0] ar;
    logic signed [SW-1:0] at, sum;
    assign ar = {1'b0, aq[QW2]} + (QW2+1)'(1);
    always_comb
    begin
        at = side_reg[LS].neg ? -$signed(SW'(ar[QW2:1])) : $signed(SW'(ar[QW2:1]));
        case (side_reg[LS].oct)
            OCT_DIRECT: sum = at;
            OCT_PLUS_PI: sum = at + PI_S;
            OCT_MINUS_PI: sum = at - PI_S;
            OCT_SWAPPED: sum = (side_reg[LS].ysgn ? -HPI_S : HPI_S) - at;
            default: sum = at;
        endcase
        if (sum > PI_S)
            sum = PI_S;
        if (sum < -PI_S)
            sum = -PI_S;
        if (side_reg[LS].org)
            sum = '0;
    end

    logic [ANGLE_WIDTH-1:0] ang_reg;
    logic org_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg <= sum[ANGLE_WIDTH-1:0];
            org_reg <= side_reg[LS].org;
        end
    end

    assign out_s.valid = vld_reg[NS-1];
    assign out_s.data = {org_reg, ang_reg};

    `AR_ASSERT_NEXT(a_hold, clk, rst_n, out_s.valid && !out_s.ready, out_s.valid)
    `AR_ASSERT(a_ready, clk, rst_n, !out_s.valid |-> in_s.ready)
    `AR_ASSERT(a_org, clk, rst_n, out_s.valid && org_reg |-> ang_reg == '0)
endmodule

// ===== design/atan2_div_cell.sv =====
// One restoring division step: one quotient bit per cell.
// The low dividend bits enter through the top of the quotient register.
// Depends on nothing.
module atan2_div_cell #(
    parameter int DW = 17,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW:0]   rem_in,
    input  logic [DW-1:0] den_in,
    input  logic [QW-1:0] q_in,
    output logic [DW:0]   rem_out,
    output logic [DW-1:0] den_out,
    output logic [QW-1:0] q_out
);
    logic [DW+1:0] sh;
    logic          ge;
    logic [DW:0]   rem_next;
    logic [QW-1:0] q_next;

    always_comb
    begin
        sh = {rem_in, q_in[QW-1]};
        ge = sh >= {2'b00, den_in};
        rem_next = ge ? (DW+1)'(sh - {2'b00, den_in}) : sh[DW:0];
        q_next = {q_in[QW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= rem_next;
            den_out <= den_in;
            q_out <= q_next;
        end
    end
endmodule

// ===== verif/tb_atan2_rational_approx.sv =====
// Self-checking testbench for the fixed-point arctangent block atan2_rational_approx.
// Depends on atan2_pkg, the atan2_stream_if interface and the block itself.
`timescale 1ns / 100ps

module tb_atan2_rational_approx;
    import atan2_pkg::*;

    localparam int XW = 16;
    localparam int AW = 16;
    localparam int AFRAC = AW - 3;
    localparam longint PI_ANGLE = longint'((PI_Q32 + (64'd1 << (31 - AFRAC))) >> (32 - AFRAC));
    localparam longint HALF_PI_ANGLE =
        longint'((PI_Q32 + (64'd1 << (32 - AFRAC))) >> (33 - AFRAC));
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int RANDOM_POINTS = 1880;

    typedef struct {
        logic signed [AW-1:0] angle;
        logic                 origin_flag;
    } angle_res_t;

    typedef struct {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        bit                   typed;
        logic signed [AW-1:0] angle;
        logic                 origin_flag;
    } point_row_t;

    logic clk;
    logic rst_n;

    atan2_stream_if #(.W(2 * XW)) pt_if ();
    atan2_stream_if #(.W(AW + 1)) ang_if ();

    atan2_rational_approx #(.IN_WIDTH(XW), .ANGLE_WIDTH(AW)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_s  (pt_if.sink),
        .out_s (ang_if.source)
    );

    angle_res_t angle_q[$];
    angle_res_t typed_q[$];
    bit         typed_flag_q[$];
    int         errors = 0;
    int         points_taken = 0;
    int         angles_taken = 0;
    int         origins_seen = 0;
    int         cycles = 0;
    int         stall_left = 0;
    bit         long_hold = 1'b0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? unsigned'(-v) : unsigned'(v);
    endfunction

    function automatic longint q15_ratio(longint num, longint den);
        bit                 neg;
        longint unsigned    q;
        neg = (num < 0) != (den < 0);
        q = ((magnitude(num) << RATIO_FRAC) + magnitude(den) / 2) / magnitude(den);
        if (!neg && q > 32767)
            q = 32767;
        if (neg && q > 32768)
            q = 32768;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint rational_atan(longint v);
        longint unsigned uv;
        longint unsigned v2;
        longint unsigned t;
        longint unsigned den;
        longint unsigned n;
        longint unsigned q;
        uv = magnitude(v);
        v2 = uv * uv;
        t = COEF_A + ((COEF_B * v2 + (64'd1 << 29)) >> 30);
        den = COEF_C + ((v2 + 2) >> 2);
        n = uv * t;
        if (AFRAC >= RATIO_FRAC)
            n = n << (AFRAC - RATIO_FRAC);
        else
            den = den << (RATIO_FRAC - AFRAC);
        q = (n + den / 2) / den;
        return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic angle_res_t point_angle(logic signed [XW-1:0] xs, logic signed [XW-1:0] ys);
        angle_res_t r;
        longint     x;
        longint     y;
        longint     a;
        x = xs;
        y = ys;
        r.origin_flag = 1'b0;
        if (x == 0 && y == 0)
        begin
            r.angle = '0;
            r.origin_flag = 1'b1;
            return r;
        end
        if (x >= 0 && magnitude(y) < magnitude(x))
            a = rational_atan(q15_ratio(y, x));
        else if (x < 0 && magnitude(y) < magnitude(x))
        begin
            a = rational_atan(q15_ratio(y, x));
            a = (y >= 0) ? a + PI_ANGLE : a - PI_ANGLE;
        end
        else
        begin
            a = rational_atan(q15_ratio(x, y));
            a = (y >= 0) ? HALF_PI_ANGLE - a : -HALF_PI_ANGLE - a;
        end
        if (a > PI_ANGLE)
            a = PI_ANGLE;
        if (a < -PI_ANGLE)
            a = -PI_ANGLE;
        r.angle = a[AW-1:0];
        return r;
    endfunction

    // Input side: record the expectation of every accepted point.
    always @(posedge clk)
    begin
        if (rst_n && pt_if.valid && pt_if.ready)
        begin
            if (typed_flag_q.pop_front())
                angle_q.push_back(typed_q.pop_front());
            else
                angle_q.push_back(point_angle(pt_if.data[XW-1:0], pt_if.data[2*XW-1:XW]));
            points_taken++;
        end
    end

    // Output side: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        angle_res_t want;
        if (rst_n && ang_if.valid && ang_if.ready)
        begin
            angles_taken++;
            if (ang_if.data[AW])
                origins_seen++;
            if (angle_q.size() == 0)
            begin
                $error("result with no point pending: angle %0d origin_flag %0b",
                       $signed(ang_if.data[AW-1:0]), ang_if.data[AW]);
                errors++;
            end
            else
            begin
                want = angle_q.pop_front();
                if (ang_if.data[AW-1:0] !== want.angle)
                begin
                    $error("angle: expected %0d, got %0d", want.angle,
                           $signed(ang_if.data[AW-1:0]));
                    errors++;
                end
                if (ang_if.data[AW] !== want.origin_flag)
                begin
                    $error("origin_flag: expected %0b, got %0b", want.origin_flag,
                           ang_if.data[AW]);
                    errors++;
                end
            end
        end
    end

    // Receiver: a random stall after each taken result except in calm stretches, and a long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (long_hold)
            ang_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            ang_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (ang_if.valid && ang_if.ready)
        begin
            if ((angles_taken / 150) % 2 == 1)
                ang_if.ready <= 1'b1;
            else
            begin
                stall_left <= $urandom_range(0, 19);
                ang_if.ready <= 1'b0;
            end
        end
        else
            ang_if.ready <= 1'b1;
    end

    initial
    begin
        wait (points_taken >= 600);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, angle_q.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_point(point_row_t row, int gap);
        angle_res_t t;
        if (gap > 0)
        begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        t.angle = row.angle;
        t.origin_flag = row.origin_flag;
        typed_flag_q.push_back(row.typed);
        if (row.typed)
            typed_q.push_back(t);
        pt_if.valid <= 1'b1;
        pt_if.data <= {row.y, row.x};
        do
            @(posedge clk);
        while (!pt_if.ready);
    endtask

    function automatic logic signed [XW-1:0] random_coord();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return 16'(int'($urandom_range(0, 8)) - 4);
            2: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        point_row_t dir[$];
        point_row_t row;
        logic signed [XW-1:0] v;
        int i;

        pt_if.valid = 1'b0;
        pt_if.data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.push_back('{16'sd0, 16'sd0, 1, 16'sd0, 1'b1});
        dir.push_back('{16'sd1, 16'sd0, 1, 16'sd0, 1'b0});
        dir.push_back('{16'sd32767, 16'sd0, 1, 16'sd0, 1'b0});
        dir.push_back('{16'sd0, 16'sd1, 1, 16'(HALF_PI_ANGLE), 1'b0});
        dir.push_back('{16'sd0, -16'sd1, 1, 16'(-HALF_PI_ANGLE), 1'b0});
        dir.push_back('{-16'sd1, 16'sd0, 1, 16'(PI_ANGLE), 1'b0});
        dir.push_back('{16'sh8000, 16'sd0, 1, 16'(PI_ANGLE), 1'b0});
        dir.push_back('{16'sd0, 16'sh8000, 1, 16'(-HALF_PI_ANGLE), 1'b0});
        dir.push_back('{16'sd100, 16'sd100, 0, 16'sd0, 1'b0});
        dir.push_back('{16'sd100, -16'sd100, 0, 16'sd0, 1'b0});
        dir.push_back('{-16'sd100, 16'sd100, 0, 16'sd0, 1'b0});
        dir.push_back('{-16'sd100, -16'sd100, 0, 16'sd0, 1'b0});
        dir.push_back('{16'sh8000, 16'sh8000, 0, 16'sd0, 1'b0});
        dir.push_back('{16'sd32767, 16'sd32767, 0, 16'sd0, 1'b0});
        dir.push_back('{16'sd32767, 16'sh8000, 0, 16'sd0, 1'b0});
        dir.push_back('{16'sh8000, 16'sd32767, 0, 16'sd0, 1'b0});
        dir.push_back('{-16'sd32767, -16'sd1, 0, 16'sd0, 1'b0});
        dir.push_back('{-16'sd32767, 16'sd1, 0, 16'sd0, 1'b0});
        dir.push_back('{16'sd3, 16'sd2, 0, 16'sd0, 1'b0});
        dir.push_back('{16'sd2, 16'sd3, 0, 16'sd0, 1'b0});
        dir.push_back('{16'sd32767, 16'sd32766, 0, 16'sd0, 1'b0});
        dir.push_back('{-16'sd5, 16'sd7, 0, 16'sd0, 1'b0});

        foreach (dir[k])
            send_point(dir[k], $urandom_range(0, 3));

        for (i = 0; i < RANDOM_POINTS; i++)
        begin
            row.typed = 0;
            row.angle = '0;
            row.origin_flag = 1'b0;
            row.x = random_coord();
            row.y = random_coord();
            case ($urandom_range(0, 7))
                0: row.y = $urandom_range(0, 1) ? row.x : -row.x;
                1:
                begin
                    v = row.x + 16'(int'($urandom_range(0, 2)) - 1);
                    row.y = $urandom_range(0, 1) ? v : -v;
                end
                2: if ($urandom_range(0, 1)) row.x = '0; else row.y = '0;
                default: ;
            endcase
            if ($urandom_range(0, 99) == 0)
            begin
                row.x = '0;
                row.y = '0;
            end
            send_point(row, ((i / 200) % 2 == 1) ? 0 : $urandom_range(0, 19));
        end
        pt_if.valid <= 1'b0;
        @(posedge clk);

        wait (angle_q.size() == 0);
        repeat (3 * (XW + AW + 8)) @(posedge clk);
        if (points_taken != angles_taken)
        begin
            $error("results: expected %0d, got %0d", points_taken, angles_taken);
            errors++;
        end
        $display("covered %0d points (%0d at the origin) through %0d results",
                 points_taken, origins_seen, angles_taken);
        $display("axes, diagonals, extremes and a long output hold-off were exercised");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
